// ----- rtl/core/dli_pkg.sv -----
package dli_pkg;

    localparam int COORD_FRAC_BITS_DEF = 4;
    localparam logic [15:0] STEP_LIMIT_RESET = 16'd10000;

    // floor(v / 10) = (v * DIV10_RECIP) >> DIV10_SHIFT, exact for v below 2^20
    localparam logic [19:0] DIV10_RECIP = 20'd838861;
    localparam int DIV10_SHIFT = 23;
    localparam logic [19:0] ROUND_NINE = 20'd9;

    localparam int DELTA_W = 18;
    localparam int NUM_W = 50;
    localparam int MAG_W = NUM_W - 1;
    localparam int CMD_QUEUE_DEPTH = 2;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_opcode;

    typedef enum logic [3:0] {
        TERM_X,
        TERM_Y,
        TERM_Z,
        TERM_R_END,
        TERM_R_START,
        TERM_G_END,
        TERM_G_START,
        TERM_B_END,
        TERM_B_START
    } t_term;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MULA,
        BK_MULB,
        BK_DSTART,
        BK_DIV,
        BK_OUT
    } t_back_state;

    typedef struct packed {
        t_opcode              op;
        logic signed [15:0]   start_x;
        logic signed [15:0]   start_y;
        logic signed [31:0]   start_depth;
        logic signed [31:0]   end_depth;
        logic [23:0]          start_color;
        logic [23:0]          end_color;
        logic signed [DELTA_W-1:0] delta_x;
        logic signed [DELTA_W-1:0] delta_y;
        logic [15:0]          steps;
    } t_cmd;

endpackage

// ----- rtl/core/dli_front.sv -----
module dli_front #(
    parameter int COORD_FRAC_BITS = dli_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic                i_opcode,
    input  logic signed [15:0]  i_start_x,
    input  logic signed [15:0]  i_start_y,
    input  logic signed [31:0]  i_start_depth,
    input  logic signed [15:0]  i_end_x,
    input  logic signed [15:0]  i_end_y,
    input  logic signed [31:0]  i_end_depth,
    input  logic [23:0]         i_start_color,
    input  logic [23:0]         i_end_color,
    input  logic                i_cfg_valid,
    input  logic [15:0]         i_cfg_data,
    output logic                o_cmd_valid,
    output dli_pkg::t_cmd       o_cmd,
    input  logic                i_queue_full
);

    localparam logic [19:0] ROUND_NINE_SH = dli_pkg::ROUND_NINE << COORD_FRAC_BITS;

    logic                r_s1_valid;
    dli_pkg::t_opcode    r_op;
    logic signed [15:0]  r_x1;
    logic signed [15:0]  r_y1;
    logic signed [31:0]  r_z1;
    logic signed [31:0]  r_z2;
    logic [23:0]         r_c1;
    logic [23:0]         r_c2;
    logic [19:0]         r_vx;
    logic [19:0]         r_vy;
    logic                r_negx;
    logic                r_negy;
    logic [15:0]         r_step_limit;

    logic                accept;
    logic                advance;
    logic signed [16:0]  dx;
    logic signed [16:0]  dy;
    logic [16:0]         magx;
    logic [16:0]         magy;
    logic [19:0]         n_vx;
    logic [19:0]         n_vy;
    logic [39:0]         prodx;
    logic [39:0]         prody;
    logic [16:0]         qx;
    logic [16:0]         qy;
    logic [16:0]         qmax;

    assign advance = r_s1_valid && !i_queue_full;
    assign o_full  = r_s1_valid && i_queue_full;
    assign accept  = i_push && !o_full;

    assign dx   = {i_end_x[15], i_end_x} - {i_start_x[15], i_start_x};
    assign dy   = {i_end_y[15], i_end_y} - {i_start_y[15], i_start_y};
    assign magx = dx[16] ? 17'(-dx) : 17'(dx);
    assign magy = dy[16] ? 17'(-dy) : 17'(dy);

    // Ten times the magnitude plus 0.9 of a pixel, then whole pixels times ten.
    assign n_vx = ({magx, 3'b000} + 20'({magx, 1'b0}) + (ROUND_NINE_SH))
                  >> COORD_FRAC_BITS;
    assign n_vy = ({magy, 3'b000} + 20'({magy, 1'b0}) + (ROUND_NINE_SH))
                  >> COORD_FRAC_BITS;

    assign prodx = r_vx * dli_pkg::DIV10_RECIP;
    assign prody = r_vy * dli_pkg::DIV10_RECIP;
    assign qx    = prodx[dli_pkg::DIV10_SHIFT +: 17];
    assign qy    = prody[dli_pkg::DIV10_SHIFT +: 17];
    assign qmax  = (qx > qy) ? qx : qy;

    always_comb begin
        o_cmd_valid       = r_s1_valid;
        o_cmd.op          = r_op;
        o_cmd.start_x     = r_x1;
        o_cmd.start_y     = r_y1;
        o_cmd.start_depth = r_z1;
        o_cmd.end_depth   = r_z2;
        o_cmd.start_color = r_c1;
        o_cmd.end_color   = r_c2;
        o_cmd.delta_x     = r_negx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
        o_cmd.delta_y     = r_negy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
        o_cmd.steps       = (qmax > {1'b0, r_step_limit}) ? r_step_limit : qmax[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_step_limit <= dli_pkg::STEP_LIMIT_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_step_limit <= i_cfg_data;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= dli_pkg::t_opcode'(i_opcode);
            r_x1   <= i_start_x;
            r_y1   <= i_start_y;
            r_z1   <= i_start_depth;
            r_z2   <= i_end_depth;
            r_c1   <= i_start_color;
            r_c2   <= i_end_color;
            r_vx   <= n_vx;
            r_vy   <= n_vy;
            r_negx <= dx[16];
            r_negy <= dy[16];
        end
    end

endmodule

// ----- rtl/core/dli_cmd_queue.sv -----
module dli_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  dli_pkg::t_cmd  i_cmd,
    output logic           o_full,
    input  logic           i_rd,
    output dli_pkg::t_cmd  o_cmd,
    output logic           o_empty
);

    localparam int PTR_W = (dli_pkg::CMD_QUEUE_DEPTH > 1) ? $clog2(dli_pkg::CMD_QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(dli_pkg::CMD_QUEUE_DEPTH + 1);

    dli_pkg::t_cmd  r_mem [dli_pkg::CMD_QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_wr;
    logic do_rd;

    assign o_full  = (r_count == CNT_W'(dli_pkg::CMD_QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(dli_pkg::CMD_QUEUE_DEPTH - 1)) ? '0
                            : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(dli_pkg::CMD_QUEUE_DEPTH - 1)) ? '0
                            : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- rtl/core/dli_divider.sv -----
module dli_divider #(
    parameter int MAG_W = dli_pkg::MAG_W,
    parameter int DVS_W = 16 + dli_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MAG_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [MAG_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(MAG_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [MAG_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   trial;
    logic             fits;

    assign trial      = {r_rem, r_quo[MAG_W-1]};
    assign fits       = (trial >= {1'b0, r_dvs});
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MAG_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // One quotient bit per cycle, most significant first.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[MAG_W-2:0], fits};
            r_rem <= fits ? DVS_W'(trial - {1'b0, r_dvs}) : trial[DVS_W-1:0];
        end
    end

endmodule

// ----- rtl/core/dli_back.sv -----
module dli_back #(
    parameter int COORD_FRAC_BITS = dli_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dli_pkg::t_cmd       i_cmd,
    input  logic                i_queue_empty,
    output logic                o_queue_rd,
    output logic                o_empty,
    input  logic                i_pop,
    output logic signed [11:0]  o_pixel_x,
    output logic signed [11:0]  o_pixel_y,
    output logic signed [31:0]  o_pixel_depth,
    output logic [23:0]         o_pixel_color,
    output logic                o_last_pixel
);

    localparam int NUM_W = dli_pkg::NUM_W;
    localparam int MAG_W = dli_pkg::MAG_W;
    localparam int DVS_W = 16 + COORD_FRAC_BITS;

    dli_pkg::t_back_state r_state;
    dli_pkg::t_back_state n_state;
    dli_pkg::t_term       r_term;

    logic signed [15:0]   r_x1;
    logic signed [15:0]   r_y1;
    logic signed [31:0]   r_z1;
    logic signed [31:0]   r_z2;
    logic [23:0]          r_c1;
    logic [23:0]          r_c2;
    logic signed [dli_pkg::DELTA_W-1:0] r_dx;
    logic signed [dli_pkg::DELTA_W-1:0] r_dy;
    logic [15:0]          r_total;
    logic [15:0]          r_k;
    logic                 r_active;
    logic                 r_last_pend;

    logic signed [NUM_W-1:0] r_pa;
    logic signed [NUM_W-1:0] r_num;
    logic [7:0]           r_chan;
    logic [11:0]          r_wx;
    logic [11:0]          r_wy;
    logic [31:0]          r_wz;
    logic [23:0]          r_wcol;
    logic                 r_out_valid;

    logic [15:0]          neff;
    logic [15:0]          nmk;
    logic [16:0]          k_next;
    logic signed [33:0]   mul_a;
    logic [15:0]          mul_b;
    logic signed [50:0]   prod;
    logic signed [NUM_W-1:0] prod_b;
    logic                 is_pos;
    logic [DVS_W-1:0]     divisor;
    logic                 num_neg;
    logic [MAG_W-1:0]     num_mag;
    logic                 div_start;
    logic                 div_done;
    logic [MAG_W-1:0]     quo;
    logic signed [NUM_W-1:0] quo_s;
    logic                 out_load;
    logic                 cmd_take;

    // A line of zero steps is worked as one step at index zero.
    assign neff   = (r_total == 16'd0) ? 16'd1 : r_total;
    assign nmk    = neff - r_k;
    assign k_next = {1'b0, r_k} + 17'd1;
    assign is_pos = r_term inside {dli_pkg::TERM_X, dli_pkg::TERM_Y};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == dli_pkg::BK_MULA) begin
            case (r_term)
                dli_pkg::TERM_X: begin
                    mul_a = {{18{r_x1[15]}}, r_x1};
                    mul_b = neff;
                end
                dli_pkg::TERM_Y: begin
                    mul_a = {{18{r_y1[15]}}, r_y1};
                    mul_b = neff;
                end
                dli_pkg::TERM_Z: begin
                    mul_a = {{2{r_z1[31]}}, r_z1};
                    mul_b = neff;
                end
                dli_pkg::TERM_R_END: begin
                    mul_a = {26'd0, r_c2[7:0]};
                    mul_b = r_k;
                end
                dli_pkg::TERM_R_START: begin
                    mul_a = {26'd0, r_c1[7:0]};
                    mul_b = nmk;
                end
                dli_pkg::TERM_G_END: begin
                    mul_a = {26'd0, r_c2[15:8]};
                    mul_b = r_k;
                end
                dli_pkg::TERM_G_START: begin
                    mul_a = {26'd0, r_c1[15:8]};
                    mul_b = nmk;
                end
                dli_pkg::TERM_B_END: begin
                    mul_a = {26'd0, r_c2[23:16]};
                    mul_b = r_k;
                end
                dli_pkg::TERM_B_START: begin
                    mul_a = {26'd0, r_c1[23:16]};
                    mul_b = nmk;
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end else begin
            case (r_term)
                dli_pkg::TERM_X: begin
                    mul_a = {{(34 - dli_pkg::DELTA_W){r_dx[dli_pkg::DELTA_W-1]}}, r_dx};
                    mul_b = r_k;
                end
                dli_pkg::TERM_Y: begin
                    mul_a = {{(34 - dli_pkg::DELTA_W){r_dy[dli_pkg::DELTA_W-1]}}, r_dy};
                    mul_b = r_k;
                end
                dli_pkg::TERM_Z: begin
                    mul_a = {{2{r_z2[31]}}, r_z2} - {{2{r_z1[31]}}, r_z1};
                    mul_b = r_k;
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    assign prod   = mul_a * $signed({1'b0, mul_b});
    assign prod_b = is_pos ? (prod[NUM_W-1:0] <<< COORD_FRAC_BITS) : prod[NUM_W-1:0];

    assign divisor = is_pos ? {neff, {COORD_FRAC_BITS{1'b0}}} : DVS_W'(neff);
    assign num_neg = r_num[NUM_W-1];
    assign num_mag = num_neg ? MAG_W'(-r_num) : MAG_W'(r_num);
    assign quo_s   = num_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

    dli_divider #(
        .MAG_W (MAG_W),
        .DVS_W (DVS_W)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (num_mag),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    assign cmd_take = (r_state == dli_pkg::BK_IDLE) && !i_queue_empty;
    assign out_load = (r_state == dli_pkg::BK_OUT) && (!r_out_valid || i_pop);

    always_comb begin
        n_state = r_state;
        case (r_state)
            dli_pkg::BK_IDLE: begin
                if (!i_queue_empty && (i_cmd.op == dli_pkg::OP_START || r_active)) begin
                    n_state = dli_pkg::BK_MULA;
                end
            end
            dli_pkg::BK_MULA:   n_state = dli_pkg::BK_MULB;
            dli_pkg::BK_MULB:   n_state = dli_pkg::BK_DSTART;
            dli_pkg::BK_DSTART: n_state = dli_pkg::BK_DIV;
            dli_pkg::BK_DIV: begin
                if (div_done) begin
                    n_state = (r_term == dli_pkg::TERM_B_START) ? dli_pkg::BK_OUT
                              : dli_pkg::BK_MULA;
                end
            end
            dli_pkg::BK_OUT: begin
                if (out_load) begin
                    n_state = dli_pkg::BK_IDLE;
                end
            end
            default: n_state = dli_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_queue_rd = cmd_take;
        div_start  = (r_state == dli_pkg::BK_DSTART);
        o_empty    = !r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dli_pkg::BK_IDLE;
            r_active    <= 1'b0;
            r_last_pend <= 1'b0;
            r_out_valid <= 1'b0;
            r_term      <= dli_pkg::TERM_X;
            r_k         <= '0;
            r_total     <= '0;
        end else begin
            r_state <= n_state;
            if (cmd_take) begin
                r_term <= dli_pkg::TERM_X;
                if (i_cmd.op == dli_pkg::OP_START) begin
                    r_total     <= i_cmd.steps;
                    r_k         <= '0;
                    r_active    <= (i_cmd.steps != 16'd0);
                    r_last_pend <= (i_cmd.steps == 16'd0);
                end else if (r_active) begin
                    if (k_next >= {1'b0, r_total}) begin
                        r_k         <= r_total;
                        r_active    <= 1'b0;
                        r_last_pend <= 1'b1;
                    end else begin
                        r_k         <= k_next[15:0];
                        r_last_pend <= 1'b0;
                    end
                end
            end
            if (r_state == dli_pkg::BK_DIV && div_done
                    && r_term != dli_pkg::TERM_B_START) begin
                r_term <= dli_pkg::t_term'(r_term + 4'd1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_take && i_cmd.op == dli_pkg::OP_START) begin
            r_x1 <= i_cmd.start_x;
            r_y1 <= i_cmd.start_y;
            r_z1 <= i_cmd.start_depth;
            r_z2 <= i_cmd.end_depth;
            r_c1 <= i_cmd.start_color;
            r_c2 <= i_cmd.end_color;
            r_dx <= i_cmd.delta_x;
            r_dy <= i_cmd.delta_y;
        end
        if (r_state == dli_pkg::BK_MULA) begin
            r_pa <= prod[NUM_W-1:0];
        end
        if (r_state == dli_pkg::BK_MULB) begin
            r_num <= r_pa + prod_b;
        end
        if (r_state == dli_pkg::BK_DIV && div_done) begin
            case (r_term)
                dli_pkg::TERM_X:       r_wx <= quo_s[11:0];
                dli_pkg::TERM_Y:       r_wy <= quo_s[11:0];
                dli_pkg::TERM_Z:       r_wz <= quo_s[31:0];
                dli_pkg::TERM_R_START: r_wcol[7:0]   <= r_chan + quo[7:0];
                dli_pkg::TERM_G_START: r_wcol[15:8]  <= r_chan + quo[7:0];
                dli_pkg::TERM_B_START: r_wcol[23:16] <= r_chan + quo[7:0];
                default:               r_chan <= quo[7:0];
            endcase
        end
        if (out_load) begin
            o_pixel_x     <= r_wx;
            o_pixel_y     <= r_wy;
            o_pixel_depth <= r_wz;
            o_pixel_color <= r_wcol;
            o_last_pixel  <= r_last_pend;
        end
    end

endmodule

// ----- rtl/core/dda_line_interpolator_core.sv -----
// Line interpolator: a start item loads two endpoints and yields the first
// pixel of the line; each later step item yields the next pixel, and the
// final pixel carries o_last_pixel. A step item with no line under way gives
// no pixel, and a start item abandons any line in progress.
// Items enter through a queue-style port: a transfer happens on push with
// full low. Pixels leave the same way: the oldest pixel is on the o_pixel_*
// ports while empty is low and is transferred on pop.
// The step limit is written on the cfg channel, which is always ready.
// A front stage classifies each item and works out the pixel deltas and the
// step count in one registered stage, and holds the registered command until
// the two-entry queue has room.
// The back engine evaluates each pixel as nine exact quotients (x, y, depth,
// two per colour channel) through one shared bit-serial divider of 49 steps,
// one quotient after another, and takes no new item until the pixel is output.
// While a pixel waits on the output, the front keeps taking items until the
// queue and its own register are full, then raises full.
// Reset clears all valid flags and the line state and sets the step limit to
// 10000; no pixel is pending after reset.
module dda_line_interpolator_core #(
    parameter int COORD_FRAC_BITS = dli_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic                i_opcode,
    input  logic signed [15:0]  i_start_x,
    input  logic signed [15:0]  i_start_y,
    input  logic signed [31:0]  i_start_depth,
    input  logic signed [15:0]  i_end_x,
    input  logic signed [15:0]  i_end_y,
    input  logic signed [31:0]  i_end_depth,
    input  logic [23:0]         i_start_color,
    input  logic [23:0]         i_end_color,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data,
    output logic                empty,
    input  logic                pop,
    output logic signed [11:0]  o_pixel_x,
    output logic signed [11:0]  o_pixel_y,
    output logic signed [31:0]  o_pixel_depth,
    output logic [23:0]         o_pixel_color,
    output logic                o_last_pixel
);

    dli_pkg::t_cmd front_cmd;
    dli_pkg::t_cmd queue_cmd;
    logic          front_valid;
    logic          queue_full;
    logic          queue_empty;
    logic          queue_rd;

    assign o_cfg_ready = 1'b1;

    dli_front #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_opcode      (i_opcode),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_start_depth (i_start_depth),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_end_depth   (i_end_depth),
        .i_start_color (i_start_color),
        .i_end_color   (i_end_color),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .o_cmd_valid   (front_valid),
        .o_cmd         (front_cmd),
        .i_queue_full  (queue_full)
    );

    dli_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_valid),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_rd    (queue_rd),
        .o_cmd   (queue_cmd),
        .o_empty (queue_empty)
    );

    dli_back #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (queue_cmd),
        .i_queue_empty (queue_empty),
        .o_queue_rd    (queue_rd),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_depth (o_pixel_depth),
        .o_pixel_color (o_pixel_color),
        .o_last_pixel  (o_last_pixel)
    );

endmodule
